// ===== src/multi_button_debouncer_top_defines.svh =====
// Assertion macros shared by the button debouncer modules.
`ifndef MULTI_BUTTON_DEBOUNCER_TOP_DEFINES_SVH
`define MULTI_BUTTON_DEBOUNCER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and disabled during reset.
`define MBD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled during reset.
`define MBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mbd_pkg.sv =====
// Shared constants and types of the button debouncer.
`default_nettype none

package mbd_pkg;

    localparam int DEB_W  = 10;
    localparam int HOLD_W = 16;

    localparam logic [DEB_W-1:0]  STABLE_MAX = '1;
    localparam logic [HOLD_W-1:0] HOLD_MAX   = '1;

    localparam int CFG_W = 1;

    localparam logic [CFG_W-1:0] CFG_ENABLE_MASK    = 1'b0;
    localparam logic [CFG_W-1:0] CFG_DEBOUNCE_TICKS = 1'b1;

    typedef struct packed {
        logic level;
        logic press;
        logic release_flag;
        logic held;
    } t_lane_res;

endpackage

`default_nettype wire

// ===== src/mbd_lane.sv =====
// Debounce, edge flag and hold counter state of one button.
`default_nettype none
`include "multi_button_debouncer_top_defines.svh"

module mbd_lane import mbd_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic              i_enable,
    input  wire logic [DEB_W-1:0]  i_debounce_ticks,
    input  wire logic              i_raw,
    input  wire logic              i_ack_press,
    input  wire logic              i_ack_release,
    input  wire logic [HOLD_W-1:0] i_hold_ms,
    output t_lane_res              o_res
);

    logic              r_last_raw;
    logic              r_stable_level;
    logic              r_press_flag;
    logic              r_release_flag;
    logic [DEB_W-1:0]  r_stable_count;
    logic [HOLD_W-1:0] r_hold_count;

    logic              n_last_raw;
    logic              n_stable_level;
    logic              n_press_flag;
    logic              n_release_flag;
    logic [DEB_W-1:0]  n_stable_count;
    logic [HOLD_W-1:0] n_hold_count;

    always_comb begin
        n_last_raw     = 1'b1;
        n_stable_level = 1'b1;
        n_press_flag   = 1'b0;
        n_release_flag = 1'b0;
        n_stable_count = '0;
        n_hold_count   = '0;
        if (i_enable) begin
            n_press_flag   = r_press_flag & ~i_ack_press;
            n_release_flag = r_release_flag & ~i_ack_release;
            n_last_raw     = i_raw;
            n_stable_level = r_stable_level;
            if (i_raw != r_last_raw) begin
                n_stable_count = '0;
            end else if (r_stable_count < STABLE_MAX) begin
                n_stable_count = r_stable_count + DEB_W'(1);
            end else begin
                n_stable_count = r_stable_count;
            end
            if (!r_stable_level && (r_hold_count < HOLD_MAX)) begin
                n_hold_count = r_hold_count + HOLD_W'(1);
            end else begin
                n_hold_count = r_hold_count;
            end
            if ((n_stable_count >= i_debounce_ticks) && (n_last_raw != r_stable_level)) begin
                n_stable_level = n_last_raw;
                if (!n_last_raw) begin
                    n_press_flag = 1'b1;
                    n_hold_count = '0;
                end else begin
                    n_release_flag = 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_res.level        = n_stable_level;
        o_res.press        = n_press_flag;
        o_res.release_flag = n_release_flag;
        o_res.held         = !n_stable_level && (n_hold_count >= i_hold_ms);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw     <= 1'b1;
            r_stable_level <= 1'b1;
            r_press_flag   <= 1'b0;
            r_release_flag <= 1'b0;
            r_stable_count <= '0;
            r_hold_count   <= '0;
        end else if (i_step) begin
            r_last_raw     <= n_last_raw;
            r_stable_level <= n_stable_level;
            r_press_flag   <= n_press_flag;
            r_release_flag <= n_release_flag;
            r_stable_count <= n_stable_count;
            r_hold_count   <= n_hold_count;
        end
    end

    `MBD_ASSERT_NOW(a_held_needs_low, o_res.held, !o_res.level, "Held button is not low.")
    `MBD_ASSERT_NEXT(a_disabled_clears, i_step && !i_enable,
                     r_stable_level && !r_press_flag && !r_release_flag && (r_hold_count == '0),
                     "Disabled button kept state.")

endmodule

`default_nettype wire

// ===== src/mbd_merge.sv =====
// Gathers the lane results into one beat and buffers it with a skid stage.
`default_nettype none
`include "multi_button_debouncer_top_defines.svh"

module mbd_merge import mbd_pkg::*; #(
    parameter int BUTTON_COUNT = 4
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_push,
    input  wire t_lane_res               i_res [BUTTON_COUNT],
    input  wire logic                    i_out_stall,
    output logic                         o_full,
    output logic                         o_out_valid,
    output logic [BUTTON_COUNT-1:0]      o_debounced_levels,
    output logic [BUTTON_COUNT-1:0]      o_press_pending,
    output logic [BUTTON_COUNT-1:0]      o_release_pending,
    output logic [BUTTON_COUNT-1:0]      o_held_mask
);

    localparam int DATA_W = 4 * BUTTON_COUNT;

    logic [DATA_W-1:0] n_data;
    logic [DATA_W-1:0] r_out_data;
    logic [DATA_W-1:0] r_skid_data;
    logic              r_out_valid;
    logic              r_skid_valid;
    logic              out_taken;

    always_comb begin
        for (int i = 0; i < BUTTON_COUNT; i++) begin
            n_data[i]                  = i_res[i].level;
            n_data[BUTTON_COUNT + i]   = i_res[i].press;
            n_data[2*BUTTON_COUNT + i] = i_res[i].release_flag;
            n_data[3*BUTTON_COUNT + i] = i_res[i].held;
        end
    end

    assign out_taken = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_taken) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_taken) begin
            r_out_data <= r_skid_valid ? r_skid_data : n_data;
        end
        if (i_push && !(!r_out_valid || out_taken)) begin
            r_skid_data <= n_data;
        end
    end

    assign o_full             = r_skid_valid;
    assign o_out_valid        = r_out_valid;
    assign o_debounced_levels = r_out_data[BUTTON_COUNT-1:0];
    assign o_press_pending    = r_out_data[2*BUTTON_COUNT-1:BUTTON_COUNT];
    assign o_release_pending  = r_out_data[3*BUTTON_COUNT-1:2*BUTTON_COUNT];
    assign o_held_mask        = r_out_data[4*BUTTON_COUNT-1:3*BUTTON_COUNT];

    `MBD_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid, "Skid stage filled ahead of output.")
    `MBD_ASSERT_NEXT(a_push_while_held, i_push && r_out_valid && i_out_stall,
                     r_skid_valid && r_out_valid, "Beat lost while output stalled.")

endmodule

`default_nettype wire

// ===== src/multi_button_debouncer_top.sv =====
// Top level of the multi-button debouncer with edge flags and hold detection.
//
// Each input beat is one millisecond tick carrying the raw active-low button
// levels, press and release acknowledge masks and a hold threshold. Every
// accepted beat yields exactly one output beat with the debounced levels,
// the pending press and release flags and the held mask.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low. The configuration port writes enable_mask (index 0) and
// debounce_ticks (index 1); the user writes them only while idle, and the
// block does not enforce it. One lane per button updates its state in the
// cycle a beat is accepted; the result is registered and a new beat can be
// accepted every cycle while o_in_stall is low. When the receiver stalls, one
// further beat is held in a skid stage, after which o_in_stall rises until
// the output drains. Synchronous reset clears all button state, empties the
// output stage, sets enable_mask to zero and debounce_ticks to twenty.
`default_nettype none

module multi_button_debouncer_top import mbd_pkg::*; #(
    parameter int BUTTON_COUNT = 4,
    localparam int CFG_DATA_W = (BUTTON_COUNT > DEB_W) ? BUTTON_COUNT : DEB_W
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_W-1:0]        i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [BUTTON_COUNT-1:0] i_raw_levels,
    input  wire logic [BUTTON_COUNT-1:0] i_ack_press,
    input  wire logic [BUTTON_COUNT-1:0] i_ack_release,
    input  wire logic [HOLD_W-1:0]       i_hold_ms,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic [BUTTON_COUNT-1:0]      o_debounced_levels,
    output logic [BUTTON_COUNT-1:0]      o_press_pending,
    output logic [BUTTON_COUNT-1:0]      o_release_pending,
    output logic [BUTTON_COUNT-1:0]      o_held_mask
);

    logic [BUTTON_COUNT-1:0] r_enable_mask;
    logic [DEB_W-1:0]        r_debounce_ticks;
    logic                    in_accept;
    logic                    full;
    t_lane_res               lane_res [BUTTON_COUNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable_mask    <= '0;
            r_debounce_ticks <= DEB_W'(20);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENABLE_MASK:    r_enable_mask    <= i_cfg_data[BUTTON_COUNT-1:0];
                CFG_DEBOUNCE_TICKS: r_debounce_ticks <= i_cfg_data[DEB_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = full;
    assign in_accept  = i_in_valid && !full;

    for (genvar g = 0; g < BUTTON_COUNT; g++) begin : g_lane
        mbd_lane u_lane (
            .i_clk            (i_clk),
            .i_rst_n          (i_rst_n),
            .i_step           (in_accept),
            .i_enable         (r_enable_mask[g]),
            .i_debounce_ticks (r_debounce_ticks),
            .i_raw            (i_raw_levels[g]),
            .i_ack_press      (i_ack_press[g]),
            .i_ack_release    (i_ack_release[g]),
            .i_hold_ms        (i_hold_ms),
            .o_res            (lane_res[g])
        );
    end

    mbd_merge #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_merge (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (in_accept),
        .i_res              (lane_res),
        .i_out_stall        (i_out_stall),
        .o_full             (full),
        .o_out_valid        (o_out_valid),
        .o_debounced_levels (o_debounced_levels),
        .o_press_pending    (o_press_pending),
        .o_release_pending  (o_release_pending),
        .o_held_mask        (o_held_mask)
    );

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the debouncer: random ticks with handshake gaps, checked beat by beat.
`timescale 1ns / 1ps

module tb_top;
    import mbd_pkg::*;

    localparam int NB         = 4;
    localparam int CFG_DW     = (NB > DEB_W) ? NB : DEB_W;
    localparam int CYCLE_CAP  = 1_000_000;
    localparam int SOAK_TICKS = 100;

    typedef struct packed {
        logic [NB-1:0] levels;
        logic [NB-1:0] press;
        logic [NB-1:0] rel;
        logic [NB-1:0] held;
    } t_report;

    class debounce_scoreboard;
        logic [NB-1:0]     enable;
        logic [DEB_W-1:0]  deb_ticks;
        logic [NB-1:0]     last_raw;
        logic [NB-1:0]     level;
        logic [NB-1:0]     press_f;
        logic [NB-1:0]     rel_f;
        logic [DEB_W-1:0]  stab_cnt [NB];
        logic [HOLD_W-1:0] hold_cnt [NB];
        t_report           pending_reports [$];
        int                errors;

        function new();
            enable    = '0;
            deb_ticks = DEB_W'(20);
            last_raw  = '1;
            level     = '1;
            press_f   = '0;
            rel_f     = '0;
            errors    = 0;
            for (int b = 0; b < NB; b++) begin
                stab_cnt[b] = '0;
                hold_cnt[b] = '0;
            end
        endfunction

        function void write_reg(logic [CFG_W-1:0] idx, logic [CFG_DW-1:0] val);
            case (idx)
                CFG_ENABLE_MASK:    enable = val[NB-1:0];
                CFG_DEBOUNCE_TICKS: deb_ticks = val[DEB_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_tick(logic [NB-1:0] raw, logic [NB-1:0] ackp,
                                logic [NB-1:0] ackr, logic [HOLD_W-1:0] hold);
            t_report rep;
            rep = '0;
            for (int b = 0; b < NB; b++) begin
                if (!enable[b]) begin
                    last_raw[b]    = 1'b1;
                    level[b]       = 1'b1;
                    press_f[b]     = 1'b0;
                    rel_f[b]       = 1'b0;
                    stab_cnt[b]    = '0;
                    hold_cnt[b]    = '0;
                    rep.levels[b]  = 1'b1;
                    continue;
                end
                if (ackp[b]) press_f[b] = 1'b0;
                if (ackr[b]) rel_f[b] = 1'b0;
                if (raw[b] != last_raw[b]) begin
                    last_raw[b] = raw[b];
                    stab_cnt[b] = '0;
                end else if (stab_cnt[b] != STABLE_MAX) begin
                    stab_cnt[b] = stab_cnt[b] + 1'b1;
                end
                if (!level[b] && hold_cnt[b] != HOLD_MAX)
                    hold_cnt[b] = hold_cnt[b] + 1'b1;
                if (stab_cnt[b] >= deb_ticks && last_raw[b] != level[b]) begin
                    level[b] = last_raw[b];
                    if (!level[b]) begin
                        press_f[b]  = 1'b1;
                        hold_cnt[b] = '0;
                    end else begin
                        rel_f[b] = 1'b1;
                    end
                end
                rep.levels[b] = level[b];
                rep.press[b]  = press_f[b];
                rep.rel[b]    = rel_f[b];
                rep.held[b]   = !level[b] && (hold_cnt[b] >= hold);
            end
            pending_reports.push_back(rep);
        endfunction

        function void check_report(t_report got);
            t_report exp;
            if (pending_reports.size() == 0) begin
                $error("output beat %h arrived with no expectation waiting", got);
                errors++;
                return;
            end
            exp = pending_reports.pop_front();
            if (got.levels !== exp.levels) begin
                $error("debounced_levels: expected %h, got %h", exp.levels, got.levels);
                errors++;
            end
            if (got.press !== exp.press) begin
                $error("press_pending: expected %h, got %h", exp.press, got.press);
                errors++;
            end
            if (got.rel !== exp.rel) begin
                $error("release_pending: expected %h, got %h", exp.rel, got.rel);
                errors++;
            end
            if (got.held !== exp.held) begin
                $error("held_mask: expected %h, got %h", exp.held, got.held);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_reports.size();
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_W-1:0]  i_cfg_index;
    logic [CFG_DW-1:0] i_cfg_data;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [NB-1:0]     i_raw_levels;
    logic [NB-1:0]     i_ack_press;
    logic [NB-1:0]     i_ack_release;
    logic [HOLD_W-1:0] i_hold_ms;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [NB-1:0]     o_debounced_levels;
    logic [NB-1:0]     o_press_pending;
    logic [NB-1:0]     o_release_pending;
    logic [NB-1:0]     o_held_mask;

    debounce_scoreboard sb;
    bit                 no_idle = 1'b0;
    int                 cycle_count = 0;
    logic [NB-1:0]      intent;
    int                 run_left [NB];

    multi_button_debouncer_top #(
        .BUTTON_COUNT(NB)
    ) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_raw_levels       (i_raw_levels),
        .i_ack_press        (i_ack_press),
        .i_ack_release      (i_ack_release),
        .i_hold_ms          (i_hold_ms),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_debounced_levels (o_debounced_levels),
        .o_press_pending    (o_press_pending),
        .o_release_pending  (o_release_pending),
        .o_held_mask        (o_held_mask)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit take_break();
        return !no_idle && ($urandom_range(99) < 33);
    endfunction

    always @(negedge i_clk) begin
        i_out_stall <= i_rst_n ? take_break() : 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_report(t_report'({o_debounced_levels, o_press_pending,
                                       o_release_pending, o_held_mask}));
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_tick(input logic [NB-1:0] raw, input logic [NB-1:0] ackp,
                             input logic [NB-1:0] ackr, input logic [HOLD_W-1:0] hold);
        while (take_break()) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_raw_levels  <= raw;
        i_ack_press   <= ackp;
        i_ack_release <= ackr;
        i_hold_ms     <= hold;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_tick(raw, ackp, ackr, hold);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [CFG_DW-1:0] val);
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int ticks, input int deb, input bit noisy);
        logic [NB-1:0]     raw;
        logic [NB-1:0]     ackp;
        logic [NB-1:0]     ackr;
        logic [HOLD_W-1:0] hold;
        for (int t = 0; t < ticks; t++) begin
            for (int b = 0; b < NB; b++) begin
                if (run_left[b] <= 0) begin
                    intent[b]   = ~intent[b];
                    run_left[b] = $urandom_range(1, 2 * deb + 6);
                end
                run_left[b]--;
                raw[b] = intent[b] ^ ($urandom_range(99) < 8);
            end
            if (noisy) raw = NB'($urandom);
            ackp = NB'($urandom & $urandom);
            ackr = NB'($urandom & $urandom);
            case ($urandom_range(9))
                0:       hold = HOLD_W'($urandom);
                1:       hold = $urandom_range(1) ? HOLD_MAX : '0;
                default: hold = HOLD_W'($urandom_range(0, deb + 30));
            endcase
            send_tick(raw, ackp, ackr, hold);
        end
    endtask

    task automatic hold_soak();
        logic [NB-1:0]     raw;
        logic [HOLD_W-1:0] hold;
        for (int t = 0; t < SOAK_TICKS; t++) begin
            raw[0] = (t >= 60);
            raw[1] = 1'b1;
            raw[2] = ((t / 20) % 2) != 0;
            raw[3] = $urandom_range(1);
            if (t % 64 == 0)
                hold = HOLD_MAX;
            else if (t % 64 == 1)
                hold = HOLD_MAX - 1'b1;
            else
                hold = HOLD_W'($urandom);
            send_tick(raw, ($urandom_range(15) == 0) ? NB'($urandom) : '0,
                      ($urandom_range(15) == 0) ? NB'($urandom) : '0, hold);
        end
    endtask

    initial begin
        int                deb;
        logic [NB-1:0]     en;
        logic [CFG_DW-1:0] cfg_val;

        sb            = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_ENABLE_MASK;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_raw_levels  = '1;
        i_ack_press   = '0;
        i_ack_release = '0;
        i_hold_ms     = '0;
        intent        = '1;
        for (int b = 0; b < NB; b++) run_left[b] = 1;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // All buttons disabled out of reset: everything must read released.
        send_tick(4'h0, 4'hF, 4'hF, HOLD_MAX);
        write_reg(CFG_ENABLE_MASK, '1);
        write_reg(CFG_DEBOUNCE_TICKS, '0);
        send_tick(4'h0, 4'h0, 4'h0, 16'h0000);
        send_tick(4'h0, 4'h0, 4'h0, 16'h0001);
        send_tick(4'h0, 4'hF, 4'h0, HOLD_MAX);
        send_tick(4'hF, 4'h0, 4'h0, 16'h0000);
        send_tick(4'hF, 4'h0, 4'hF, 16'h0000);
        send_tick(4'hA, 4'h0, 4'h0, 16'h0000);
        send_tick(4'h5, 4'h0, 4'h0, 16'h8000);
        send_tick(4'h5, 4'h5, 4'hA, 16'h7FFF);
        // Disable two buttons while one of them is pressed, then bring them back.
        write_reg(CFG_ENABLE_MASK, CFG_DW'(4'h3));
        send_tick(4'h0, 4'h0, 4'h0, 16'h0000);
        write_reg(CFG_ENABLE_MASK, CFG_DW'(4'hF));
        send_tick(4'h0, 4'h0, 4'h0, 16'h0002);
        write_reg(CFG_DEBOUNCE_TICKS, CFG_DW'(2));
        send_tick(4'hF, 4'h0, 4'h0, 16'h0000);
        send_tick(4'h0, 4'h0, 4'h0, 16'h0000);
        send_tick(4'hF, 4'h0, 4'h0, 16'h0000);
        send_tick(4'hF, 4'h0, 4'h0, 16'h0000);
        send_tick(4'hF, 4'hF, 4'h0, 16'h0000);
        send_tick(4'hF, 4'h0, 4'hF, 16'h0000);

        for (int p = 0; p < 12; p++) begin
            case ($urandom_range(5))
                0:       deb = 0;
                1:       deb = 1;
                2, 3:    deb = $urandom_range(2, 4);
                4:       deb = $urandom_range(5, 12);
                default: deb = 20;
            endcase
            en = ($urandom_range(3) != 0) ? 4'hF : NB'($urandom);
            cfg_val = CFG_DW'($urandom);
            cfg_val[NB-1:0] = en;
            write_reg(CFG_ENABLE_MASK, cfg_val);
            write_reg(CFG_DEBOUNCE_TICKS, CFG_DW'(deb));
            no_idle = (p == 5) || (p == 6);
            random_phase(100, deb, (p == 3) || (p == 9));
        end
        no_idle = 1'b0;

        // Longest debounce: no raw change may be accepted within this short run.
        write_reg(CFG_ENABLE_MASK, '0);
        send_tick(4'h0, 4'h0, 4'h0, 16'h0000);
        write_reg(CFG_ENABLE_MASK, '1);
        write_reg(CFG_DEBOUNCE_TICKS, '1);
        hold_soak();
        i_in_valid <= 1'b0;

        for (int n = 0; n < 1000 && sb.outstanding() != 0; n++) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (sb.outstanding() != 0) begin
            $error("%0d expected output beats never arrived", sb.outstanding());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/mbd_pkg.sv
src/mbd_lane.sv
src/mbd_merge.sv
src/multi_button_debouncer_top.sv
bench/tb_top.sv
